// ===== hw/rtl/gcl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and constants for the gate controller
// Mode and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int CODE_LENGTH_DEF = 4;
  localparam int CODE_LENGTH_MAX = 8;

  localparam logic [31:0] PASS_CODE_RESET  = 32'h3132_3334;  // "1234"
  localparam logic [15:0] AUTO_CLOSE_RESET = 16'd2000;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [0:0] {
    CFG_PASS_CODE  = 1'b0,
    CFG_AUTO_CLOSE = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    MODE_START     = 3'd0,
    MODE_OPENING   = 3'd1,
    MODE_OPEN_WAIT = 3'd2,
    MODE_CLOSING   = 3'd3,
    MODE_LOCKED    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_KEY        = 3'd1,
    EV_WRONG      = 3'd2,
    EV_RIGHT      = 3'd3,
    EV_OPEN       = 3'd4,
    EV_AUTO_CLOSE = 3'd5,
    EV_CLOSED     = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    DRIVE_STOP  = 2'd0,
    DRIVE_OPEN  = 2'd1,
    DRIVE_CLOSE = 2'd2
  } drive_t;

  typedef struct packed {
    event_t event_code;
    mode_t  gate_mode;
    drive_t motor_drive;
  } result_t;

endpackage

// ===== hw/rtl/gate_controller_with_code_lock.sv =====
// ----------------------------------------------------------------------------
// gate_controller_with_code_lock: gate motor controller with keypad lock
// Drives a two-wire gate motor from tick and key-press items, with a
// keypad code lock and an auto-close countdown.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer. in_tuser is the kind (0 tick, 1 key press),
//           in_tdata carries the key code and both active-low limit switches.
//   out_* : exactly one result per input item, in order: motor drive, gate
//           mode after the item, and an event code.
//   cfg_* : register writes (pass code, auto-close ticks), taken at once
//           while cfg_we is high; write only while the block is idle.
// Timing:
//   Each item is processed in the cycle it is accepted and its result is
//   registered for out_*. One item per cycle is sustained while in_tready is
//   high: mode register and countdown update in a single pass of small logic.
// Stall:
//   The result register is backed by one skid entry, so in_tready comes
//   from a flop. When the receiver stalls, one more item is taken into the
//   skid entry, then in_tready drops until the result register drains.
// Reset:
//   rst_n (synchronous) empties both result slots, returns to the start mode,
//   clears the key count and loads the register reset values. The first item
//   after reset only picks the mode from the limit switches.
// ----------------------------------------------------------------------------
module gate_controller_with_code_lock
  import gcl_pkg::*;
#(
  parameter int CODE_LENGTH = CODE_LENGTH_DEF  // 1..8 keys per code
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] key_code, [8] closed_switch, [9] open_switch, [15:10] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] action
  input  logic                   in_tuser,

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] motor_drive, [4:2] gate_mode, [7:5] event_code
  output logic [OUT_TDATA_W-1:0] out_tdata,

  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int KW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [KW-1:0] LAST_POS = KW'(CODE_LENGTH - 1);

  // Registers
  logic [31:0]   pass_code_r;
  logic [15:0]   auto_close_r;
  mode_t         mode_r, mode_nxt;
  logic [KW-1:0] keys_cnt_r, keys_cnt_nxt;
  logic [15:0]   countdown_r, countdown_nxt;
  logic [7:0]    keys_r [CODE_LENGTH];

  // Item fields
  logic       in_fire;
  logic       is_key;
  logic [7:0] key_code;
  logic       closed_at;   // gate fully closed (switch low)
  logic       open_at;     // gate fully open (switch low)

  assign in_fire   = in_tvalid & in_tready;
  assign is_key    = in_tuser;
  assign key_code  = in_tdata[7:0];
  assign closed_at = ~in_tdata[8];
  assign open_at   = ~in_tdata[9];

  // Expected keys: key i is byte (CODE_LENGTH-1-i) of the pass code; bytes
  // above bit 31 read as zero.
  logic [63:0] code_ext;
  logic [7:0]  expected [CODE_LENGTH];
  logic        code_match;

  assign code_ext = {32'd0, pass_code_r};

  always_comb begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      expected[i] = code_ext[(CODE_LENGTH - 1 - i) * 8 +: 8];
    end
  end

  // Last key is compared straight from the input, earlier ones from storage
  always_comb begin
    code_match = (key_code == expected[CODE_LENGTH - 1]);
    for (int i = 0; i < CODE_LENGTH - 1; i++) begin
      if (keys_r[i] != expected[i]) begin
        code_match = 1'b0;
      end
    end
  end

  logic last_key;
  assign last_key = (keys_cnt_r == LAST_POS);

  // Next-state logic
  always_comb begin
    mode_nxt      = mode_r;
    keys_cnt_nxt  = keys_cnt_r;
    countdown_nxt = countdown_r;
    unique case (mode_r)
      MODE_START: begin
        if (closed_at) begin
          mode_nxt = MODE_LOCKED;
        end else if (open_at) begin
          mode_nxt = MODE_CLOSING;
        end else begin
          mode_nxt = MODE_OPENING;
        end
        keys_cnt_nxt = '0;
      end
      MODE_OPENING: begin
        if (open_at && !closed_at) begin
          mode_nxt      = MODE_OPEN_WAIT;
          countdown_nxt = auto_close_r;
        end
      end
      MODE_OPEN_WAIT: begin
        if (!is_key) begin
          if (countdown_r <= 16'd1) begin
            countdown_nxt = '0;
            mode_nxt      = MODE_CLOSING;
          end else begin
            countdown_nxt = countdown_r - 16'd1;
          end
        end
      end
      MODE_CLOSING: begin
        if (closed_at && !open_at) begin
          mode_nxt     = MODE_LOCKED;
          keys_cnt_nxt = '0;
        end
      end
      MODE_LOCKED: begin
        if (is_key) begin
          if (last_key) begin
            keys_cnt_nxt = '0;
            if (code_match) begin
              mode_nxt = MODE_OPENING;
            end
          end else begin
            keys_cnt_nxt = keys_cnt_r + KW'(1);
          end
        end
      end
      default: begin
        mode_nxt = MODE_START;
      end
    endcase
  end

  // Output logic: event for this item, drive from the new mode
  result_t res;

  always_comb begin
    res.event_code = EV_NONE;
    unique case (mode_r)
      MODE_OPENING: begin
        if (open_at && !closed_at) res.event_code = EV_OPEN;
      end
      MODE_OPEN_WAIT: begin
        if (!is_key && countdown_r <= 16'd1) res.event_code = EV_AUTO_CLOSE;
      end
      MODE_CLOSING: begin
        if (closed_at && !open_at) res.event_code = EV_CLOSED;
      end
      MODE_LOCKED: begin
        if (is_key) begin
          if (!last_key) begin
            res.event_code = EV_KEY;
          end else if (code_match) begin
            res.event_code = EV_RIGHT;
          end else begin
            res.event_code = EV_WRONG;
          end
        end
      end
      default: begin
        res.event_code = EV_NONE;
      end
    endcase

    res.gate_mode = mode_nxt;
    unique case (mode_nxt)
      MODE_OPENING: res.motor_drive = DRIVE_OPEN;
      MODE_CLOSING: res.motor_drive = DRIVE_CLOSE;
      default:      res.motor_drive = DRIVE_STOP;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_code_r  <= PASS_CODE_RESET;
      auto_close_r <= AUTO_CLOSE_RESET;
      mode_r       <= MODE_START;
      keys_cnt_r   <= '0;
      countdown_r  <= AUTO_CLOSE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_PASS_CODE:  pass_code_r  <= cfg_wdata[31:0];
          CFG_AUTO_CLOSE: auto_close_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        mode_r      <= mode_nxt;
        keys_cnt_r  <= keys_cnt_nxt;
        countdown_r <= countdown_nxt;
      end
    end
  end

  // Key store: written only in locked mode, read only after being written
  always_ff @(posedge clk) begin
    if (in_fire && mode_r == MODE_LOCKED && is_key) begin
      keys_r[keys_cnt_r] <= key_code;
    end
  end

  // Result register plus one skid entry
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, skid_data_r;
  logic    load_out, load_skid;

  assign load_skid = in_fire & out_valid_r & ~out_tready;
  assign load_out  = (skid_valid_r & out_tready)
                   | (in_fire & (~out_valid_r | out_tready));

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_skid) begin
      skid_valid_nxt = 1'b1;
    end else if (out_tready) begin
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (load_skid) begin
      skid_data_r <= res;
    end
  end

  assign in_tready  = ~skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/gcl_checker.sv =====
// ----------------------------------------------------------------------------
// gcl_checker: port-level checks for the gate controller
// Watches the result channel for mode, drive and event consistency.
// ----------------------------------------------------------------------------
module gcl_checker
  import gcl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  result_t r;
  assign r = out_tdata;

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Drive follows mode; start mode is never reported
  a_drive_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> r.gate_mode != MODE_START
      && ((r.gate_mode == MODE_OPENING) == (r.motor_drive == DRIVE_OPEN))
      && ((r.gate_mode == MODE_CLOSING) == (r.motor_drive == DRIVE_CLOSE)))
    else $error("motor drive does not match gate mode");

  // Each event lands in the mode it implies
  a_event_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (r.event_code != EV_RIGHT      || r.gate_mode == MODE_OPENING)
      && (r.event_code != EV_OPEN    || r.gate_mode == MODE_OPEN_WAIT)
      && (r.event_code != EV_AUTO_CLOSE || r.gate_mode == MODE_CLOSING)
      && (r.event_code != EV_CLOSED  || r.gate_mode == MODE_LOCKED)
      && (r.event_code != EV_KEY     || r.gate_mode == MODE_LOCKED)
      && (r.event_code != EV_WRONG   || r.gate_mode == MODE_LOCKED))
    else $error("event code does not match gate mode");

endmodule

bind gate_controller_with_code_lock gcl_checker u_gcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
